// ===== sv/crsl_pkg.sv =====
// shared types, codes and constants for the circular station ring
// used by the controller, the datapath, the top level and the checker
// depends on nothing
package crsl_pkg;

  localparam int ID_W           = 10;
  localparam int MAX_ID         = 1023;
  localparam int DEPTH          = MAX_ID + 1;
  localparam int MIN_FOR_REMOVE = 2;
  localparam int CMD_W          = 3;
  localparam int ST_W           = 3;

  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_NEXT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_PREV   = 3'd4;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_REF_INACTIVE = 3'd1,
    ST_NEW_ACTIVE   = 3'd2,
    ST_TOO_FEW      = 3'd3,
    ST_LOAD_CLOSED  = 3'd4,
    ST_ID_ZERO      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_DECIDE,
    S_LINK
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  station;
    logic [ID_W-1:0]  new_station;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] affected_station;
    logic [ID_W-1:0] ring_size;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic fetch;
    logic decide;
    logic link;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic ok;
  } dp_stat_t;

  function automatic logic id_ok(input logic [ID_W-1:0] id);
    id_ok = (id != '0) && (int'(id) <= MAX_ID);
  endfunction

endpackage

// ===== sv/crsl_ctrl.sv =====
// controller state machine for the circular station ring
// sequences clear, accept, fetch, decide and link steps of the datapath
// depends on crsl_pkg
module crsl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  crsl_pkg::dp_stat_t  stat,
  output crsl_pkg::ctrl_cmd_t cmd,
  output logic                busy
);

  crsl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crsl_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      crsl_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_nxt = crsl_pkg::S_IDLE;
        end
      end
      crsl_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = crsl_pkg::S_FETCH;
        end
      end
      crsl_pkg::S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = crsl_pkg::S_DECIDE;
      end
      crsl_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.ok ? crsl_pkg::S_LINK : crsl_pkg::S_IDLE;
      end
      crsl_pkg::S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = crsl_pkg::S_IDLE;
      end
      default: begin
        state_nxt = crsl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/crsl_dp.sv =====
// datapath of the circular station ring: next, previous and active memories,
// rule checks, pointer rewiring and the result register
// depends on crsl_pkg
module crsl_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  crsl_pkg::ctrl_cmd_t cmd,
  input  crsl_pkg::in_t       in_data,
  output crsl_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output crsl_pkg::out_t      out_data
);

  localparam int W = crsl_pkg::ID_W;

  // single-port memories, registered read
  logic [W-1:0] next_mem [crsl_pkg::DEPTH];
  logic [W-1:0] prev_mem [crsl_pkg::DEPTH];
  logic         act_mem  [crsl_pkg::DEPTH];

  logic [W-1:0] next_rd_r, prev_rd_r;
  logic         act_rd_r;

  crsl_pkg::in_t item_r;
  logic          act_ref_r;
  logic [W-1:0]  nref_r, pref_r, gone_r, aft_r;
  logic [W-1:0]  total_r, total_nxt;
  logic [W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic          loading_r, loading_nxt;
  logic [W-1:0]  clr_addr_r;
  logic          out_valid_r, out_valid_nxt;
  crsl_pkg::out_t out_r, out_nxt;

  logic [crsl_pkg::CMD_W-1:0] op;
  logic [W-1:0]      ref_id, nw_id, gone, bef, aft;
  logic              is_remove, is_add, ok_step;
  crsl_pkg::status_t status;

  logic [W-1:0] ptr_addr_n, ptr_addr_p, ptr_data_n, ptr_data_p;
  logic         ptr_we, ptr_re;
  logic [W-1:0] act_addr;
  logic         act_wdata, act_we, act_re;

  assign op        = item_r.command;
  assign ref_id    = item_r.station;
  assign nw_id     = item_r.new_station;
  assign is_remove = (op == crsl_pkg::CMD_REM_NEXT) || (op == crsl_pkg::CMD_REM_PREV);
  assign is_add    = (op == crsl_pkg::CMD_APPEND) || (op == crsl_pkg::CMD_INS_AFTER)
                  || (op == crsl_pkg::CMD_INS_BEFORE);
  assign gone      = (op == crsl_pkg::CMD_REM_NEXT) ? next_rd_r : prev_rd_r;

  // rule checks, in the order the ring defines them
  always_comb begin
    status = crsl_pkg::ST_OK;
    case (op)
      crsl_pkg::CMD_APPEND: begin
        if (!loading_r) begin
          status = crsl_pkg::ST_LOAD_CLOSED;
        end else if (!crsl_pkg::id_ok(nw_id)) begin
          status = crsl_pkg::ST_ID_ZERO;
        end else if (act_rd_r) begin
          status = crsl_pkg::ST_NEW_ACTIVE;
        end
      end
      crsl_pkg::CMD_INS_AFTER, crsl_pkg::CMD_INS_BEFORE,
      crsl_pkg::CMD_REM_NEXT, crsl_pkg::CMD_REM_PREV: begin
        if (!crsl_pkg::id_ok(ref_id)) begin
          status = crsl_pkg::ST_ID_ZERO;
        end else if (!act_ref_r) begin
          status = crsl_pkg::ST_REF_INACTIVE;
        end else if (is_add) begin
          if (!crsl_pkg::id_ok(nw_id)) begin
            status = crsl_pkg::ST_ID_ZERO;
          end else if (act_rd_r) begin
            status = crsl_pkg::ST_NEW_ACTIVE;
          end
        end else if (int'(total_r) < crsl_pkg::MIN_FOR_REMOVE) begin
          status = crsl_pkg::ST_TOO_FEW;
        end
      end
      default: begin
        status = crsl_pkg::ST_LOAD_CLOSED;
      end
    endcase
  end

  assign ok_step         = cmd.decide && (status == crsl_pkg::ST_OK);
  assign stat.ok         = (status == crsl_pkg::ST_OK);
  assign stat.clear_done = (clr_addr_r == W'(crsl_pkg::MAX_ID));

  // neighbors around the spot being linked or unlinked
  always_comb begin
    bef = '0;
    aft = '0;
    case (op)
      crsl_pkg::CMD_APPEND: begin
        if (total_r == '0) begin
          bef = nw_id;
          aft = nw_id;
        end else begin
          bef = tail_r;
          aft = head_r;
        end
      end
      crsl_pkg::CMD_INS_AFTER: begin
        bef = ref_id;
        aft = nref_r;
      end
      crsl_pkg::CMD_INS_BEFORE: begin
        bef = pref_r;
        aft = ref_id;
      end
      crsl_pkg::CMD_REM_NEXT, crsl_pkg::CMD_REM_PREV: begin
        bef = prev_rd_r;
        aft = next_rd_r;
      end
      default: begin
        bef = '0;
        aft = '0;
      end
    endcase
  end

  // pointer memory ports: read at accept and fetch, write at decide (if the rules pass) and link
  always_comb begin
    ptr_re     = cmd.accept || cmd.fetch;
    ptr_we     = ok_step || cmd.link;
    ptr_addr_n = gone;
    ptr_addr_p = gone;
    ptr_data_n = '0;
    ptr_data_p = '0;
    if (cmd.accept) begin
      ptr_addr_n = in_data.station;
      ptr_addr_p = in_data.station;
    end else if (cmd.decide) begin
      ptr_addr_n = bef;
      ptr_data_n = is_remove ? aft : nw_id;
      ptr_addr_p = is_remove ? aft : nw_id;
      ptr_data_p = bef;
    end else if (cmd.link) begin
      ptr_addr_n = is_remove ? gone_r : nw_id;
      ptr_data_n = is_remove ? '0 : aft_r;
      ptr_addr_p = is_remove ? gone_r : aft_r;
      ptr_data_p = is_remove ? '0 : nw_id;
    end
  end

  always_ff @(posedge clk) begin
    if (ptr_we) begin
      next_mem[ptr_addr_n] <= ptr_data_n;
      prev_mem[ptr_addr_p] <= ptr_data_p;
    end
    if (ptr_re) begin
      next_rd_r <= next_mem[ptr_addr_n];
      prev_rd_r <= prev_mem[ptr_addr_p];
    end
  end

  // active mark port: cleared after reset, one entry a cycle
  always_comb begin
    act_re    = cmd.accept || cmd.fetch;
    act_we    = cmd.clear || ok_step;
    act_wdata = 1'b0;
    act_addr  = is_remove ? gone_r : nw_id;
    if (cmd.clear) begin
      act_addr = clr_addr_r;
    end else if (cmd.accept) begin
      act_addr = in_data.station;
    end else if (cmd.fetch) begin
      act_addr = nw_id;
    end else begin
      act_wdata = !is_remove;
    end
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_addr] <= act_wdata;
    end
    if (act_re) begin
      act_rd_r <= act_mem[act_addr];
    end
  end

  // item and fetched pointers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.fetch) begin
      act_ref_r <= act_rd_r;
      nref_r    <= next_rd_r;
      pref_r    <= prev_rd_r;
      gone_r    <= gone;
    end
    if (cmd.decide) begin
      aft_r <= aft;
    end
  end

  // ring bookkeeping, committed at decide
  always_comb begin
    total_nxt   = total_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    loading_nxt = loading_r;
    if (ok_step) begin
      if (is_remove) begin
        total_nxt   = total_r - W'(1);
        loading_nxt = 1'b0;
      end else begin
        total_nxt = total_r + W'(1);
        if (op == crsl_pkg::CMD_APPEND) begin
          tail_nxt = nw_id;
          if (total_r == '0) begin
            head_nxt = nw_id;
          end
        end else begin
          loading_nxt = 1'b0;
        end
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (cmd.decide && !stat.ok) begin
      out_valid_nxt            = 1'b1;
      out_nxt.status           = status;
      out_nxt.affected_station = '0;
      out_nxt.ring_size        = total_r;
    end else if (cmd.link) begin
      out_valid_nxt            = 1'b1;
      out_nxt.status           = crsl_pkg::ST_OK;
      out_nxt.affected_station = is_remove ? gone_r : nw_id;
      out_nxt.ring_size        = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      loading_r   <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      loading_r   <= loading_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/circular_ring_station_list_unit.sv =====
// circular station ring: ids kept in a doubly linked ring in on-chip memories
// usage and timing notes below; instantiates crsl_ctrl and crsl_dp
// depends on crsl_pkg
//
// input channel: drive in_data with start high; the item is taken at a rising
// edge where start is high and busy is low.
// result channel: one result per item, shown on out_data for exactly one cycle
// with out_valid high; the receiver cannot stall it.
// timing: an item is taken, its pointers are fetched from the next, previous
// and active memories at accept and then at fetch (the lookup of the removed
// station's neighbors depends on the first read), then the rules are checked
// and, if they pass, the first pair of pointer writes is made at decide.
// accepted items make the second pair at link: each memory has a single port.
//   rejected item: result registered at decide, busy high until it shows
//   accepted item: result registered at link, busy high until it shows
// busy drops in the cycle out_valid is high, so a new item can follow at once.
// reset: synchronous, active low. afterwards the active marks are swept to
// zero over every entry, one entry a cycle, while busy stays high.
module circular_ring_station_list_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  crsl_pkg::in_t  in_data,
  output logic           out_valid,
  output crsl_pkg::out_t out_data
);

  crsl_pkg::ctrl_cmd_t cmd;
  crsl_pkg::dp_stat_t  stat;

  crsl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  crsl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sv/crsl_checker.sv =====
// port-level checks for the circular station ring
// attached to circular_ring_station_list_unit by the bind below
// depends on crsl_pkg
module crsl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input crsl_pkg::in_t  in_data,
  input logic           out_valid,
  input crsl_pkg::out_t out_data
);

  logic take;
  assign take = start && !busy;

  // the block is free again whenever a result shows
  a_free_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> busy)
    else $error("not busy after an item was taken");

  // no result shows during the fetch and decide steps that follow a take
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !out_valid ##1 !out_valid)
    else $error("result too soon after an item was taken");

  a_reject_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != crsl_pkg::ST_OK)) |-> (out_data.affected_station == '0))
    else $error("rejected item reports a station");

endmodule

bind circular_ring_station_list_unit crsl_checker u_crsl_checker (.*);
